@@ design/audio_peak_vu_bar_renderer_core_defines.svh @@
// Assertion macros for the checker file of the VU bar renderer.
`ifndef AUDIO_PEAK_VU_BAR_RENDERER_CORE_DEFINES_SVH
`define AUDIO_PEAK_VU_BAR_RENDERER_CORE_DEFINES_SVH

// Clocked assertion, ignored while reset is high.
`define APVU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define APVU_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/apvu_pkg.sv @@
// Types, constants and the color wheel of the VU bar renderer.
package apvu_pkg;

   localparam int HALF_PIXELS = 13;

   localparam int SAMPLE_W    = 11;
   localparam int PEAK_W      = 10;
   localparam int HUE_W       = 8;
   localparam int COLOR_W     = 8;
   localparam int INDEX_W     = 5;
   localparam int HEIGHT_W    = 6;
   localparam int GAIN_PROD_W = 16;
   localparam int HEIGHT_GAIN = 45;
   localparam int HEIGHT_SHIFT = 10;
   localparam int CSR_IDX_W   = 1;

   localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = SAMPLE_W'(1024);
   localparam logic [HUE_W-1:0]    START_HUE_RESET = HUE_W'(30);
   localparam logic [HUE_W-1:0]    END_HUE_RESET   = HUE_W'(150);

   localparam logic MODE_SAMPLE     = 1'b0;
   localparam logic MODE_WINDOW_END = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_HUE = 1'b0,
      CSR_END_HUE   = 1'b1
   } csr_index_type;

   // level counter and level arithmetic
   localparam int LVL_W      = (HALF_PIXELS > 1) ? $clog2(HALF_PIXELS) : 1;
   localparam int IDX_CALC_W = INDEX_W + 2;
   localparam int STEP_W     = HUE_W + 1;
   localparam int ACC_W      = 14;
   localparam int LVL_DIV    = (HALF_PIXELS > 1) ? HALF_PIXELS - 1 : 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W    = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] LVL_RECIP = RECIP_W'((2 ** RECIP_SHIFT) / LVL_DIV + 1);
   localparam int PROD_W     = ACC_W + RECIP_W;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;

   localparam logic [HUE_W-1:0] WHEEL_SPLIT_1 = HUE_W'(85);
   localparam logic [HUE_W-1:0] WHEEL_SPLIT_2 = HUE_W'(170);
   localparam logic [COLOR_W-1:0] COLOR_FULL  = COLOR_W'(255);

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic [HUE_W-1:0]    start_hue;
      logic [HUE_W-1:0]    end_hue;
   } frame_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   function automatic rgb_type wheel_rgb(input logic [HUE_W-1:0] pos);
      rgb_type             c;
      logic [HUE_W-1:0]    v;
      logic [COLOR_W-1:0]  v3;
      begin
         if (pos < WHEEL_SPLIT_1) begin
            v = pos;
         end else if (pos < WHEEL_SPLIT_2) begin
            v = pos - WHEEL_SPLIT_1;
         end else begin
            v = pos - WHEEL_SPLIT_2;
         end
         v3 = COLOR_W'({v, 1'b0}) + COLOR_W'(v);
         if (pos < WHEEL_SPLIT_1) begin
            c.red   = v3;
            c.green = COLOR_FULL - v3;
            c.blue  = '0;
         end else if (pos < WHEEL_SPLIT_2) begin
            c.red   = COLOR_FULL - v3;
            c.green = '0;
            c.blue  = v3;
         end else begin
            c.red   = '0;
            c.green = v3;
            c.blue  = COLOR_FULL - v3;
         end
         return c;
      end
   endfunction

endpackage

@@ design/apvu_front.sv @@
// Front side: sample intake, window peak tracking, bar height and hue registers.
module apvu_front
   import apvu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [HUE_W-1:0]      csr_wdata,
   input  fifo_status_type       fifo_status,
   output logic                  push,
   output frame_cmd_type         push_data
);

   logic [PEAK_W-1:0]      max_ff, max_in;
   logic [SAMPLE_W-1:0]    min_ff, min_in;
   logic [HUE_W-1:0]       start_hue_ff, end_hue_ff;
   logic                   accept;
   logic [PEAK_W-1:0]      p2p;
   logic [GAIN_PROD_W-1:0] gain_prod;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_data.mode == MODE_WINDOW_END);

   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (accept) begin
         if (req_data.mode == MODE_WINDOW_END) begin
            max_in = '0;
            min_in = SAMPLE_LIMIT;
         end else if (req_data.sample < SAMPLE_LIMIT) begin
            if (req_data.sample[PEAK_W-1:0] > max_ff) begin
               max_in = req_data.sample[PEAK_W-1:0];
            end
            if (req_data.sample < min_ff) begin
               min_in = req_data.sample;
            end
         end
      end
   end

   // saturate at zero when the window saw nothing
   always_comb begin
      if (SAMPLE_W'(max_ff) > min_ff) begin
         p2p = PEAK_W'(SAMPLE_W'(max_ff) - min_ff);
      end else begin
         p2p = '0;
      end
      gain_prod = GAIN_PROD_W'(p2p) * GAIN_PROD_W'(HEIGHT_GAIN);
   end

   assign push_data.height    = gain_prod[HEIGHT_SHIFT +: HEIGHT_W];
   assign push_data.start_hue = start_hue_ff;
   assign push_data.end_hue   = end_hue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         min_ff       <= SAMPLE_LIMIT;
         start_hue_ff <= START_HUE_RESET;
         end_hue_ff   <= END_HUE_RESET;
      end else begin
         max_ff <= max_in;
         min_ff <= min_in;
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_START_HUE: start_hue_ff <= csr_wdata;
               CSR_END_HUE:   end_hue_ff   <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

endmodule

@@ design/apvu_fifo.sv @@
// Frame command queue between the front and the render side.
module apvu_fifo
   import apvu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_cmd_type   push_data,
   input  logic            pop,
   output frame_cmd_type   pop_data,
   output fifo_status_type status
);

   frame_cmd_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [FIFO_PTR_W:0]   count_ff;

   assign status.full  = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

@@ design/apvu_render.sv @@
// Render side: walks levels outward, one colored pixel per cycle unless stalled.
module apvu_render
   import apvu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  frame_cmd_type   pop_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);

   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(HALF_PIXELS - 1);

   // pixel generator
   logic                     active_ff;
   logic [LVL_W-1:0]         lvl_ff;
   logic                     side_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [HEIGHT_W-1:0]      height_ff;
   logic [HUE_W-1:0]         hue_ff;
   logic signed [STEP_W-1:0] step_ff;

   // hue stage and output stage
   logic                     s1_valid_ff;
   logic [INDEX_W-1:0]       s1_idx_ff;
   logic                     s1_lit_ff;
   logic [HUE_W-1:0]         s1_hue_ff;
   logic                     s1_last_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic                     advance;
   logic [IDX_CALC_W-1:0]    idx_full;
   logic                     acc_neg;
   logic [ACC_W-1:0]         acc_abs;
   logic [PROD_W-1:0]        quot_prod;
   logic [HUE_W-1:0]         quot;
   logic [HUE_W-1:0]         hue_in;
   rgb_type                  wheel_c;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop       = !active_ff && !fifo_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (side_ff) begin
         idx_full = IDX_CALC_W'(HALF_PIXELS) + IDX_CALC_W'(lvl_ff);
      end else begin
         idx_full = IDX_CALC_W'(HALF_PIXELS - 1) - IDX_CALC_W'(lvl_ff);
      end
   end

   // level offset: acc holds lvl*(end-start); divide by HALF_PIXELS-1
   // through a reciprocal multiply, truncating toward zero
   always_comb begin
      acc_neg   = acc_ff[ACC_W-1];
      acc_abs   = acc_neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      quot_prod = PROD_W'(acc_abs) * PROD_W'(LVL_RECIP);
      quot      = quot_prod[RECIP_SHIFT +: HUE_W];
      hue_in    = acc_neg ? (hue_ff - quot) : (hue_ff + quot);
   end

   assign wheel_c = wheel_rgb(s1_hue_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         height_ff <= pop_data.height;
         hue_ff    <= pop_data.start_hue;
         step_ff   <= STEP_W'(pop_data.end_hue) - STEP_W'(pop_data.start_hue);
      end
      if (advance) begin
         s1_idx_ff  <= idx_full[INDEX_W-1:0];
         s1_lit_ff  <= (HEIGHT_W'(lvl_ff) < height_ff);
         s1_hue_ff  <= hue_in;
         s1_last_ff <= side_ff && (lvl_ff == LAST_LVL);
         rsp_data_ff.pixel_index <= s1_idx_ff;
         rsp_data_ff.last        <= s1_last_ff;
         if (s1_lit_ff) begin
            rsp_data_ff.red   <= wheel_c.red;
            rsp_data_ff.green <= wheel_c.green;
            rsp_data_ff.blue  <= wheel_c.blue;
         end else begin
            rsp_data_ff.red   <= '0;
            rsp_data_ff.green <= '0;
            rsp_data_ff.blue  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         lvl_ff       <= '0;
         side_ff      <= 1'b0;
         acc_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff  <= active_ff;
            rsp_valid_ff <= s1_valid_ff;
         end
         if (pop) begin
            active_ff <= 1'b1;
            lvl_ff    <= '0;
            side_ff   <= 1'b0;
            acc_ff    <= '0;
         end else if (advance && active_ff) begin
            if (!side_ff) begin
               side_ff <= 1'b1;
            end else begin
               side_ff <= 1'b0;
               if (lvl_ff == LAST_LVL) begin
                  active_ff <= 1'b0;
               end else begin
                  lvl_ff <= lvl_ff + 1'b1;
                  acc_ff <= acc_ff + ACC_W'(step_ff);
               end
            end
         end
      end
   end

endmodule

@@ design/audio_peak_vu_bar_renderer_core.sv @@
// Top level of the peak-to-peak VU meter that renders a center-mirrored LED bar.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_type  (mode, sample)
//   rsp_      out        rsp_valid / rsp_ready  rsp_type  (pixel_index, r, g, b, last)
//   csr_      in         csr_write_en           csr_index, csr_wdata (hue registers)
//
// Samples are taken one per cycle; req_ready drops only while the frame queue is full.
// A window-end item queues one frame command; the render side emits 2*HALF_PIXELS
// pixels at one per cycle while rsp_ready does not stall it, takes the next command
// only once the frame is done, and rsp_valid follows a pop via the hue and output stages.
// Reset (synchronous, active high) empties the window and sets the hues to 30 and 150.
// A low rsp_ready with rsp_valid high freezes the render stages and holds the pixel on rsp_.
module audio_peak_vu_bar_renderer_core
   import apvu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HUE_W-1:0]     csr_wdata
);

   // front to queue
   logic            push;
   frame_cmd_type   push_data;
   // queue to render side
   logic            pop;
   frame_cmd_type   pop_data;
   fifo_status_type fifo_status;

   // Track the window peaks, form the bar height at window end and push it
   // with the current hue range.
   apvu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fifo_status  (fifo_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Hold pending frames so sampling continues while a frame drains.
   apvu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   // Walk levels from the center outward, color lit levels from the wheel.
   apvu_render u_render (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/apvu_checker.sv @@
// Port-level checker for the VU bar renderer and its bind.
`include "audio_peak_vu_bar_renderer_core_defines.svh"

module apvu_checker
   import apvu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(2 * HALF_PIXELS - 1);
   localparam int SUM_W = COLOR_W + 2;
   localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(COLOR_FULL);

   logic             stalled;
   logic             last_seen;
   logic [SUM_W-1:0] color_sum;
   logic             on_wheel;

   assign stalled   = rsp_valid && !rsp_ready;
   assign last_seen = rsp_valid && rsp_data.last;
   assign color_sum = SUM_W'(rsp_data.red) + SUM_W'(rsp_data.green)
                    + SUM_W'(rsp_data.blue);
   assign on_wheel  = (color_sum == FULL_SUM) || (color_sum == '0);

   // hold a stalled pixel
   `APVU_ASSERT(a_rsp_hold, stalled |=> rsp_valid && $stable(rsp_data), "stalled pixel changed")

   // frame ends on the outermost pixel of the upper half
   `APVU_ASSERT(a_last_index, last_seen |-> rsp_data.pixel_index == LAST_INDEX, "misplaced last")

   // wheel colors sum to full scale, unlit pixels are black
   `APVU_ASSERT(a_color_sum, rsp_valid |-> on_wheel, "pixel color off the wheel")

   // nothing leaves right after reset
   `APVU_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "pixel valid after reset")

endmodule

bind audio_peak_vu_bar_renderer_core apvu_checker u_apvu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
